/* rtl/cfd_pkg.sv */
// Shared types and constants for the command frame deframer.
`default_nettype none

package cfd_pkg;

  // Frame layout: byte offsets from the frame start and the fixed byte count.
  localparam int unsigned FRAME_OVERHEAD = 9;
  localparam int unsigned CMD_OFS        = 4;
  localparam int unsigned LEN_OFS        = 5;
  localparam int unsigned PAY_OFS        = 6;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HRD,
    ST_HCK,
    ST_ERD,
    ST_ELD,
    ST_EHOLD,
    ST_DONE
  } state_t;

  // Operations of the shared byte unit.
  typedef enum logic [1:0] {
    OP_MATCH,
    OP_LIMIT,
    OP_ACCUM
  } unit_op_t;

  // Request into the shared byte unit.
  typedef struct packed {
    unit_op_t    op;
    logic [7:0]  data;
    logic [7:0]  operand;
    logic [7:0]  acc;
  } unit_req_t;

  // Response from the shared byte unit.
  typedef struct packed {
    logic        hit;
    logic [7:0]  sum;
  } unit_rsp_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_HEAD,
    REG_SENDER,
    REG_RECEIVER,
    REG_TAIL
  } reg_idx_t;

endpackage

`default_nettype wire

/* rtl/cfd_mem.sv */
// Byte window memory with one write port and one registered read port.
`default_nettype none

module cfd_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data_r
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/cfd_unit.sv */
// Shared byte unit: equality match, upper limit compare and running sum.
`default_nettype none

module cfd_unit (
  input  wire cfd_pkg::unit_req_t req,
  output cfd_pkg::unit_rsp_t      rsp
);

  // One operation per cycle, selected by the sequencer.
  always_comb begin
    rsp.hit = 1'b0;
    rsp.sum = req.acc;
    case (req.op)
      cfd_pkg::OP_MATCH: rsp.hit = (req.data == req.operand);
      cfd_pkg::OP_LIMIT: rsp.hit = (req.data <= req.operand);
      cfd_pkg::OP_ACCUM: begin
        rsp.hit = 1'b1;
        rsp.sum = req.acc + req.data;
      end
      default: rsp.hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/command_frame_deframer_top.sv */
// Top level of the command frame deframer: sequencer, window pointers and register port.
//
// Channel   Direction  Handshake              Contents
// in_       input      in_valid / in_ready    in_rx_byte
// out_      output     out_valid / out_ready  command, payload byte and length, flags
// APB       config     psel/penable/pwrite    head, sender, receiver, tail registers
//
// Each received byte is stored while idle; each scan start is a SCAN step and each
// window byte examined a memory read (HRD), then a check in the shared unit (HCK).
// A valid frame passes each result item through a payload read (ERD, none for an
// empty payload), a load (ELD), hold over output stalls (EHOLD); DONE ends the scan.
// in_ready is high only while the sequencer is idle; reset (synchronous, active low)
// empties the window and clears the registers, and needs no clearing pass.
`default_nettype none

module command_frame_deframer_top #(
  parameter int unsigned WINDOW_DEPTH = 256,
  parameter int unsigned MAX_LEN      = 56
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_command,
  output logic [7:0]       out_payload_byte,
  output logic             out_has_payload,
  output logic [5:0]       out_payload_length,
  output logic             out_last_of_frame,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned LW = (CW > 9) ? CW : 9;
  localparam logic [PW-1:0] DEPTH_P   = PW'(WINDOW_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(WINDOW_DEPTH);
  localparam logic [7:0]    MAX_LEN_B = 8'(MAX_LEN);

  // Circular address: base plus offset, offset never above the depth.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [PW-1:0] ofs);
    logic [PW-1:0] s;
    s = PW'(base) + ofs;
    if (s >= DEPTH_P) begin
      s = s - DEPTH_P;
    end
    return s[AW-1:0];
  endfunction

  cfd_pkg::state_t state_r, state_nxt;

  logic [15:0]   head_r, tail_r;
  logic [7:0]    sender_r, receiver_r;
  logic [AW-1:0] base_r, base_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] off_r, off_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_cmd_r, out_byte_r;
  logic          out_has_r, out_last_r;
  logic [5:0]    out_len_r;

  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [AW-1:0]       mem_rd_addr;
  logic [LW-1:0]       rd_ofs;
  logic [7:0]          mem_rdata;
  cfd_pkg::unit_req_t  ureq;
  cfd_pkg::unit_rsp_t  ursp;

  logic [LW-1:0] end6;
  logic [LW-1:0] need_hdr;
  logic [LW-1:0] need_frm;
  logic          is_cmd, is_len, is_pay, is_sum, is_t0, is_t1;
  logic          short_frame;
  logic          in_acc, out_acc, cfg_wr;
  logic          item_last;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid_r && out_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      sender_r   <= '0;
      receiver_r <= '0;
      tail_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfd_pkg::reg_idx_t'(paddr[3:2]))
        cfd_pkg::REG_HEAD:     head_r     <= pwdata[15:0];
        cfd_pkg::REG_SENDER:   sender_r   <= pwdata[7:0];
        cfd_pkg::REG_RECEIVER: receiver_r <= pwdata[7:0];
        cfd_pkg::REG_TAIL:     tail_r     <= pwdata[15:0];
        default:               head_r     <= head_r;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (cfd_pkg::reg_idx_t'(paddr[3:2]))
      cfd_pkg::REG_HEAD:     prdata = {16'h0, head_r};
      cfd_pkg::REG_SENDER:   prdata = {24'h0, sender_r};
      cfd_pkg::REG_RECEIVER: prdata = {24'h0, receiver_r};
      cfd_pkg::REG_TAIL:     prdata = {16'h0, tail_r};
      default:               prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Window memory and its addressing.
  assign mem_wr_en   = in_acc;
  assign mem_wr_addr = wrap_add(base_r, PW'(count_r));
  assign rd_ofs      = (state_r == cfd_pkg::ST_ERD) ? (LW'(k_r) + LW'(cfd_pkg::PAY_OFS))
                                                     : off_r;
  assign mem_rd_addr = wrap_add(base_r, PW'(rd_ofs));

  cfd_mem #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (in_rx_byte),
    .rd_addr   (mem_rd_addr),
    .rd_data_r (mem_rdata)
  );

  // Position of the byte under check within the candidate frame.
  always_comb begin
    end6        = LW'(len_r) + LW'(cfd_pkg::PAY_OFS);
    need_hdr    = LW'(mem_rdata) + LW'(cfd_pkg::FRAME_OVERHEAD);
    need_frm    = LW'(len_r) + LW'(cfd_pkg::FRAME_OVERHEAD);
    is_cmd      = (off_r == LW'(cfd_pkg::CMD_OFS));
    is_len      = (off_r == LW'(cfd_pkg::LEN_OFS));
    is_pay      = (off_r >= LW'(cfd_pkg::PAY_OFS)) && (off_r < end6);
    is_sum      = (off_r == end6);
    is_t0       = (off_r == end6 + LW'(1));
    is_t1       = (off_r == end6 + LW'(2));
    short_frame = (LW'(count_r) < need_hdr);
    item_last   = (len_r == 8'd0) || ({1'b0, k_r} + 9'd1 == {1'b0, len_r});
  end

  // Request to the shared byte unit for the current frame position.
  always_comb begin
    ureq.op      = cfd_pkg::OP_MATCH;
    ureq.data    = mem_rdata;
    ureq.operand = 8'h00;
    ureq.acc     = sum_r;
    if (off_r == LW'(0)) begin
      ureq.operand = head_r[7:0];
    end else if (off_r == LW'(1)) begin
      ureq.operand = head_r[15:8];
    end else if (off_r == LW'(2)) begin
      ureq.operand = sender_r;
    end else if (off_r == LW'(3)) begin
      ureq.operand = receiver_r;
    end else if (is_cmd) begin
      ureq.op = cfd_pkg::OP_ACCUM;
    end else if (is_len) begin
      ureq.op      = cfd_pkg::OP_LIMIT;
      ureq.operand = MAX_LEN_B;
    end else if (is_pay) begin
      ureq.op = cfd_pkg::OP_ACCUM;
    end else if (is_sum) begin
      ureq.operand = sum_r;
    end else if (is_t0) begin
      ureq.operand = tail_r[7:0];
    end else begin
      ureq.operand = tail_r[15:8];
    end
  end

  cfd_unit u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cfd_pkg::ST_SCAN;
        end
      end
      cfd_pkg::ST_SCAN: begin
        if (count_r < CW'(cfd_pkg::FRAME_OVERHEAD)) begin
          state_nxt = cfd_pkg::ST_DONE;
        end else begin
          state_nxt = cfd_pkg::ST_HRD;
        end
      end
      cfd_pkg::ST_HRD: state_nxt = cfd_pkg::ST_HCK;
      cfd_pkg::ST_HCK: begin
        if (!ursp.hit) begin
          state_nxt = cfd_pkg::ST_SCAN;
        end else if (is_len && short_frame) begin
          state_nxt = cfd_pkg::ST_DONE;
        end else if (is_t1) begin
          state_nxt = (len_r == 8'd0) ? cfd_pkg::ST_ELD : cfd_pkg::ST_ERD;
        end else begin
          state_nxt = cfd_pkg::ST_HRD;
        end
      end
      cfd_pkg::ST_ERD: state_nxt = cfd_pkg::ST_ELD;
      cfd_pkg::ST_ELD: state_nxt = cfd_pkg::ST_EHOLD;
      cfd_pkg::ST_EHOLD: begin
        if (out_ready) begin
          state_nxt = out_last_r ? cfd_pkg::ST_DONE : cfd_pkg::ST_ERD;
        end
      end
      cfd_pkg::ST_DONE: state_nxt = cfd_pkg::ST_IDLE;
      default: state_nxt = cfd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer datapath updates.
  always_comb begin
    base_nxt      = base_r;
    count_nxt     = count_r;
    off_nxt       = off_r;
    len_nxt       = len_r;
    cmd_nxt       = cmd_r;
    sum_nxt       = sum_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      cfd_pkg::ST_IDLE: begin
        if (in_acc) begin
          count_nxt = count_r + CW'(1);
        end
      end
      cfd_pkg::ST_SCAN: begin
        off_nxt = '0;
        sum_nxt = '0;
      end
      cfd_pkg::ST_HCK: begin
        if (!ursp.hit) begin
          // Candidate failed: drop the oldest byte.
          base_nxt  = wrap_add(base_r, PW'(1));
          count_nxt = count_r - CW'(1);
        end else begin
          if (is_cmd) begin
            cmd_nxt = mem_rdata;
          end
          if (is_len) begin
            len_nxt = mem_rdata;
          end
          if (is_pay) begin
            sum_nxt = ursp.sum;
          end
          off_nxt = off_r + LW'(1);
          k_nxt   = '0;
        end
      end
      cfd_pkg::ST_ELD: begin
        out_valid_nxt = 1'b1;
      end
      cfd_pkg::ST_EHOLD: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // Frame delivered: remove it from the window.
            base_nxt  = wrap_add(base_r, PW'(need_frm));
            count_nxt = count_r - CW'(need_frm);
          end else begin
            k_nxt = k_r + 8'd1;
          end
        end
      end
      cfd_pkg::ST_DONE: begin
        // A full window without a frame is discarded.
        if (count_r == DEPTH_C) begin
          count_nxt = '0;
          base_nxt  = '0;
        end
      end
      default: begin
        off_nxt = off_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfd_pkg::ST_IDLE;
      base_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the scan.
  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    len_r <= len_nxt;
    cmd_r <= cmd_nxt;
    sum_r <= sum_nxt;
    k_r   <= k_nxt;
  end

  // Output register, loaded once per result transaction.
  always_ff @(posedge clk) begin
    if (state_r == cfd_pkg::ST_ELD) begin
      out_cmd_r  <= cmd_r;
      out_byte_r <= (len_r == 8'd0) ? 8'h00 : mem_rdata;
      out_has_r  <= (len_r != 8'd0);
      out_len_r  <= len_r[5:0];
      out_last_r <= item_last;
    end
  end

  assign in_ready           = (state_r == cfd_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_command        = out_cmd_r;
  assign out_payload_byte   = out_byte_r;
  assign out_has_payload    = out_has_r;
  assign out_payload_length = out_len_r;
  assign out_last_of_frame  = out_last_r;

  // The window never holds more bytes than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("window fill count above depth");

  // No byte is taken while a result transaction is pending.
  a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // Every accepted byte starts a scan before the next one is taken.
  a_scan_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == cfd_pkg::ST_SCAN))
    else $error("no scan after accepted byte");

  // The last result of a frame ends the scan.
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_last_of_frame |=> !out_valid && (state_r == cfd_pkg::ST_DONE))
    else $error("result after last of frame");

endmodule

`default_nettype wire

/* verif/tb_command_frame_deframer_top.sv */
// Testbench for the command frame deframer: byte stimulus, frame predictor and result checks.
`timescale 1ns / 1ps

module tb_command_frame_deframer_top;

  localparam int WINDOW_DEPTH  = 256;
  localparam int MAX_LEN       = 56;
  localparam int SETTLE_CYCLES = 16;

  // One result transaction as the block presents it.
  typedef struct packed {
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic       has_payload;
    logic [5:0] payload_length;
    logic       last_of_frame;
  } frame_item_t;

  // Kinds of byte sequences the stimulus builds.
  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_BAD_TAIL,
    FRAME_BAD_ID,
    FRAME_BAD_HEAD,
    FRAME_OVERLONG,
    FRAME_DECOY
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_command;
  logic [7:0]  out_payload_byte;
  logic        out_has_payload;
  logic [5:0]  out_payload_length;
  logic        out_last_of_frame;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // Frame format the predictor expects, kept in step with every register write.
  logic [15:0] cfg_head = 16'h0;
  logic [7:0]  cfg_sender = 8'h0;
  logic [7:0]  cfg_receiver = 8'h0;
  logic [15:0] cfg_tail = 16'h0;

  // Predictor copy of the receive window.
  logic [7:0]  win_bytes [WINDOW_DEPTH];
  int          win_fill = 0;

  logic [7:0]  byte_backlog [$];
  frame_item_t frame_items_due [$];
  frame_item_t got_item;
  frame_item_t want_item;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_taken = 0;
  int items_seen = 0;
  int frames_seen = 0;
  int mismatches = 0;

  command_frame_deframer_top #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_command(out_command),
    .out_payload_byte(out_payload_byte),
    .out_has_payload(out_has_payload),
    .out_payload_length(out_payload_length),
    .out_last_of_frame(out_last_of_frame),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clock and a single reset at the start.
  initial begin
    fork
      forever #1 clk = ~clk;
      begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
      end
    join
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("command_frame_deframer_top verification failed");
    $finish;
  end

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  // Removes the n oldest bytes from the predicted window.
  function automatic void drop_oldest(int n);
    if (n >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int k = 0; k < win_fill - n; k++) win_bytes[k] = win_bytes[k + n];
      win_fill -= n;
    end
  endfunction

  // Adds one received byte to the window, scans it and queues the items of any frame found.
  function automatic void absorb_byte(logic [7:0] rx);
    logic [15:0] head;
    logic [15:0] tail;
    logic [7:0]  sum;
    int          flen;
    bit          done;
    if (win_fill < WINDOW_DEPTH) begin
      win_bytes[win_fill] = rx;
      win_fill++;
    end
    done = 1'b0;
    while (!done && win_fill >= cfd_pkg::FRAME_OVERHEAD) begin
      head = {win_bytes[1], win_bytes[0]};
      flen = win_bytes[cfd_pkg::LEN_OFS];
      if (head != cfg_head || win_bytes[2] != cfg_sender ||
          win_bytes[3] != cfg_receiver || flen > MAX_LEN) begin
        drop_oldest(1);
      end else if (win_fill < cfd_pkg::FRAME_OVERHEAD + flen) begin
        // Header looks right but the frame is not complete yet.
        done = 1'b1;
      end else begin
        sum = 8'h00;
        for (int k = 0; k < flen; k++) sum = sum + win_bytes[cfd_pkg::PAY_OFS + k];
        tail = {win_bytes[cfd_pkg::PAY_OFS + flen + 2], win_bytes[cfd_pkg::PAY_OFS + flen + 1]};
        if (sum == win_bytes[cfd_pkg::PAY_OFS + flen] && tail == cfg_tail) begin
          if (flen == 0) begin
            frame_items_due.push_back('{win_bytes[cfd_pkg::CMD_OFS], 8'h00, 1'b0, 6'd0, 1'b1});
          end else begin
            for (int k = 0; k < flen; k++)
              frame_items_due.push_back('{win_bytes[cfd_pkg::CMD_OFS],
                                          win_bytes[cfd_pkg::PAY_OFS + k], 1'b1,
                                          6'(flen), k == flen - 1});
          end
          drop_oldest(cfd_pkg::FRAME_OVERHEAD + flen);
          done = 1'b1;
        end else begin
          drop_oldest(1);
        end
      end
    end
    if (win_fill >= WINDOW_DEPTH) win_fill = 0;
  endfunction

  // Builds one byte sequence of the given kind against the current frame format.
  function automatic void queue_frame(frame_kind_t kind, logic [7:0] cmd, int len);
    logic [15:0] head;
    logic [15:0] tail;
    logic [7:0]  snd;
    logic [7:0]  rcv;
    logic [7:0]  sum;
    logic [7:0]  pb;
    int          body;
    head = cfg_head;
    tail = cfg_tail;
    snd  = cfg_sender;
    rcv  = cfg_receiver;
    sum  = 8'h00;
    if (kind == FRAME_BAD_HEAD) head = head ^ 16'($urandom_range(1, 65535));
    if (kind == FRAME_BAD_TAIL) tail = tail ^ 16'($urandom_range(1, 65535));
    if (kind == FRAME_BAD_ID) begin
      if ($urandom_range(1)) snd = snd ^ 8'($urandom_range(1, 255));
      else rcv = rcv ^ 8'($urandom_range(1, 255));
    end
    if (kind == FRAME_OVERLONG) len = $urandom_range(MAX_LEN + 1, 255);
    body = (kind == FRAME_OVERLONG) ? 3 : len;
    byte_backlog.push_back(head[7:0]);
    byte_backlog.push_back(head[15:8]);
    byte_backlog.push_back(snd);
    byte_backlog.push_back(rcv);
    byte_backlog.push_back(cmd);
    byte_backlog.push_back(8'(len));
    // A decoy is a good header whose body never arrives.
    if (kind == FRAME_DECOY) return;
    for (int k = 0; k < body; k++) begin
      pb = 8'($urandom);
      sum = sum + pb;
      byte_backlog.push_back(pb);
    end
    if (kind == FRAME_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    byte_backlog.push_back(sum);
    byte_backlog.push_back(tail[7:0]);
    byte_backlog.push_back(tail[15:8]);
  endfunction

  // Mostly well-formed frames, with broken frames, decoy headers and line noise mixed in.
  function automatic void fill_random(int n_bytes);
    int start;
    int pick;
    int len;
    start = byte_backlog.size();
    while (byte_backlog.size() - start < n_bytes) begin
      pick = $urandom_range(99);
      len = ($urandom_range(7) == 0) ? $urandom_range(MAX_LEN) : $urandom_range(6);
      if (pick < 60) queue_frame(FRAME_GOOD, 8'($urandom), len);
      else if (pick < 66) queue_frame(FRAME_BAD_SUM, 8'($urandom), len);
      else if (pick < 71) queue_frame(FRAME_BAD_TAIL, 8'($urandom), len);
      else if (pick < 76) queue_frame(FRAME_BAD_ID, 8'($urandom), len);
      else if (pick < 79) queue_frame(FRAME_BAD_HEAD, 8'($urandom), len);
      else if (pick < 83) queue_frame(FRAME_OVERLONG, 8'($urandom), len);
      else if (pick < 88) queue_frame(FRAME_DECOY, 8'($urandom), len);
      else repeat ($urandom_range(1, 4)) byte_backlog.push_back(8'($urandom));
    end
  endfunction

  // One APB write: setup phase, then access phase.
  task automatic write_reg(cfd_pkg::reg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cfd_pkg::REG_HEAD:     cfg_head = value;
      cfd_pkg::REG_SENDER:   cfg_sender = value[7:0];
      cfd_pkg::REG_RECEIVER: cfg_receiver = value[7:0];
      cfd_pkg::REG_TAIL:     cfg_tail = value;
      default:               ;
    endcase
  endtask

  task automatic load_frame_format(logic [15:0] head, logic [7:0] snd, logic [7:0] rcv,
                                   logic [15:0] tail);
    write_reg(cfd_pkg::REG_HEAD, head);
    write_reg(cfd_pkg::REG_SENDER, 16'(snd));
    write_reg(cfd_pkg::REG_RECEIVER, 16'(rcv));
    write_reg(cfd_pkg::REG_TAIL, tail);
  endtask

  // Waits until every byte is taken, the block is idle and every expected item has come.
  task automatic settle();
    do @(negedge clk); while (byte_backlog.size() != 0 || in_valid);
    do @(negedge clk); while (frame_items_due.size() != 0 || !in_ready);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Byte driver: holds a transaction until it is taken, and predicts on each one taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_byte(in_rx_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver stalls at random.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: each result transaction against the oldest expected item.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_item = '{out_command, out_payload_byte, out_has_payload, out_payload_length,
                   out_last_of_frame};
      items_seen++;
      if (out_last_of_frame) frames_seen++;
      if (frame_items_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result cmd=%h byte=%h has=%b len=%0d last=%b",
                                got_item.command, got_item.payload_byte,
                                got_item.has_payload, got_item.payload_length,
                                got_item.last_of_frame));
      end else begin
        want_item = frame_items_due.pop_front();
        if (got_item !== want_item)
          flag_mismatch($sformatf({"result mismatch: expected cmd=%h byte=%h has=%b len=%0d ",
                                   "last=%b, got cmd=%h byte=%h has=%b len=%0d last=%b"},
                                  want_item.command, want_item.payload_byte,
                                  want_item.has_payload, want_item.payload_length,
                                  want_item.last_of_frame, got_item.command,
                                  got_item.payload_byte, got_item.has_payload,
                                  got_item.payload_length, got_item.last_of_frame));
      end
    end
  end

  // Test sequence.
  initial begin
    wait (rst_n === 1'b1);
    send_idle_pct = 24;
    recv_idle_pct = 86;
    load_frame_format(16'hAA55, 8'h12, 8'h34, 16'h0A0D);

    // Directed: a stray byte, an empty payload with an all-ones command, a short payload
    // and a payload of the largest allowed length.
    byte_backlog.push_back(8'h00);
    queue_frame(FRAME_GOOD, 8'hFF, 0);
    queue_frame(FRAME_GOOD, 8'h00, 2);
    queue_frame(FRAME_GOOD, 8'hA5, MAX_LEN);
    settle();

    fill_random(25);
    settle();

    send_idle_pct = 86;
    recv_idle_pct = 24;
    load_frame_format(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    fill_random(25);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_frame_format(16'h0000, 8'h00, 8'h00, 16'h0000);
    fill_random(25);
    settle();

    load_frame_format(16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    fill_random(25);
    settle();

    $display("Run covered %0d received bytes under four frame formats and three stall patterns.",
             bytes_taken);
    $display("Checked %0d result transactions in %0d frames, %0d mismatches.",
             items_seen, frames_seen, mismatches);
    if (mismatches == 0) begin
      $display("command_frame_deframer_top verification clean");
    end else begin
      $display("command_frame_deframer_top verification failed");
    end
    $finish;
  end

endmodule
